/* rtl/qte_pkg.sv */
// ----------------------------------------------------------------------------
// qte_pkg: quaternion to Euler angle converter shared definitions
// Widths, latency constants, cell beat types and the arctangent table.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int CORDIC_LAT    = CORDIC_STAGES + 1;
  localparam int SQRT_CELLS    = 31;
  localparam int ANG_DLY       = SQRT_CELLS + 1;
  localparam int CLAMP_DLY     = ANG_DLY + CORDIC_LAT;
  localparam int PIPE_DEPTH    = 3 + SQRT_CELLS + CORDIC_LAT + 2;

  localparam int CW = 36;
  localparam int VW = 61;
  localparam int RW = 62;

  typedef logic signed [CW-1:0] cval_t;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] ROUND_HALF   = 32'h0000_8000;
  localparam cval_t       ONE_Q30      = 36'sh0_4000_0000;
  localparam logic [VW-1:0] ONE_Q60    = 61'(1) << 60;
  localparam logic signed [15:0] PITCH_MAX = 16'sd16384;
  localparam logic [15:0] HALF_TURN    = 16'h8000;

  typedef struct packed {
    cval_t       x;
    cval_t       y;
    logic [31:0] z;
    logic        zero;
  } cordic_t;

  typedef struct packed {
    logic [VW-1:0]      v;
    logic [RW-1:0]      res;
    logic signed [31:0] s;
  } sqrt_t;

  typedef struct packed {
    logic [15:0] yaw;
    logic [15:0] roll;
    logic [15:0] lyaw;
  } angles_t;

  function automatic logic [31:0] atan_val(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10680094;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41722;
      5'd15:   r = 32'd20861;
      5'd16:   r = 32'd10431;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2608;
      5'd19:   r = 32'd1304;
      5'd20:   r = 32'd652;
      5'd21:   r = 32'd326;
      5'd22:   r = 32'd163;
      5'd23:   r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/qte_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// qte_sqrt_cell: one digit of the restoring square root
// Resolves one root bit per beat and carries the pitch sine alongside.
// ----------------------------------------------------------------------------
module qte_sqrt_cell (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [4:0]    k_i,
  input  qte_pkg::sqrt_t d_i,
  output qte_pkg::sqrt_t q_o
);

  logic [qte_pkg::RW-1:0] bit_w;
  logic [qte_pkg::RW-1:0] sum;
  qte_pkg::sqrt_t         q_d;
  qte_pkg::sqrt_t         q_q;

  always_comb begin
    bit_w = qte_pkg::RW'(1) << {k_i, 1'b0};
    sum   = d_i.res + bit_w;
    q_d   = d_i;
    if ({1'b0, d_i.v} >= sum) begin
      q_d.v   = d_i.v - sum[qte_pkg::VW-1:0];
      q_d.res = (d_i.res >> 1) + bit_w;
    end else begin
      q_d.res = d_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

/* rtl/qte_cordic_cell.sv */
// ----------------------------------------------------------------------------
// qte_cordic_cell: one vectoring micro-rotation
// Rotates towards the x axis and accumulates the binary angle.
// ----------------------------------------------------------------------------
module qte_cordic_cell (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [4:0]       shift_i,
  input  logic [31:0]      atan_i,
  input  qte_pkg::cordic_t d_i,
  output qte_pkg::cordic_t q_o
);

  qte_pkg::cval_t   dx;
  qte_pkg::cval_t   dy;
  logic             ypos;
  qte_pkg::cordic_t q_d;
  qte_pkg::cordic_t q_q;

  always_comb begin
    dx   = d_i.y >>> shift_i;
    dy   = d_i.x >>> shift_i;
    ypos = !d_i.y[qte_pkg::CW-1] && (d_i.y != '0);
    q_d  = d_i;
    if (ypos) begin
      q_d.x = d_i.x + dx;
      q_d.y = d_i.y - dy;
      q_d.z = d_i.z + atan_i;
    end else begin
      q_d.x = d_i.x - dx;
      q_d.y = d_i.y + dy;
      q_d.z = d_i.z - atan_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

/* rtl/qte_cordic.sv */
// ----------------------------------------------------------------------------
// qte_cordic: pipelined two-argument arctangent
// Quadrant pre-rotation followed by a row of micro-rotation cells.
// ----------------------------------------------------------------------------
module qte_cordic (
  input  logic           clk_i,
  input  logic           en_i,
  input  qte_pkg::cval_t y_i,
  input  qte_pkg::cval_t x_i,
  output logic [15:0]    angle_o
);

  qte_pkg::cordic_t pre_d;
  qte_pkg::cordic_t pre_q;
  qte_pkg::cordic_t stage [qte_pkg::CORDIC_STAGES+1];
  logic [31:0]      zr;

  always_comb begin
    pre_d.x    = x_i;
    pre_d.y    = y_i;
    pre_d.z    = '0;
    pre_d.zero = (x_i == '0) && (y_i == '0);
    if (x_i[qte_pkg::CW-1]) begin
      if (!y_i[qte_pkg::CW-1]) begin
        pre_d.x = y_i;
        pre_d.y = -x_i;
        pre_d.z = qte_pkg::QUARTER_TURN;
      end else begin
        pre_d.x = -y_i;
        pre_d.y = x_i;
        pre_d.z = -qte_pkg::QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_q <= pre_d;
    end
  end

  assign stage[0] = pre_q;

  for (genvar j = 0; j < qte_pkg::CORDIC_STAGES; j++) begin : g_cell
    qte_cordic_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (en_i),
      .shift_i (5'(j)),
      .atan_i  (qte_pkg::atan_val(5'(j))),
      .d_i     (stage[j]),
      .q_o     (stage[j+1])
    );
  end

  assign zr      = stage[qte_pkg::CORDIC_STAGES].z + qte_pkg::ROUND_HALF;
  assign angle_o = stage[qte_pkg::CORDIC_STAGES].zero ? 16'h0000 : zr[31:16];

endmodule

/* rtl/quaternion_to_euler_angles_top.sv */
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top: quaternion to roll, pitch and yaw
// Q1.15 quaternion in, 16-bit binary angles out (32768 = pi).
// ----------------------------------------------------------------------------
// Input channel in_valid_i/in_ready_o takes one quaternion per beat; output
// channel out_valid_o/out_ready_i gives roll, pitch, yaw and the lock and
// clamp flags. cfg_valid_i/cfg_ready_o writes lock_margin (always ready);
// write it only while the block is empty.
// From input beat to output beat the path is products, sums, the sine
// square, a 31-cell square-root row and a pitch arctangent, then two
// output stages. Roll and yaw arctangents run beside the root row and
// wait in a delay line.
// Throughput is one beat per cycle unless the output stalls. The whole
// pipeline advances as one shift register; when the output register holds
// a beat that is not taken, every stage holds and in_ready_o drops until
// out_ready_i returns. Reset empties the pipeline and zeroes lock_margin.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [15:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o,
  output logic               gimbal_lock_o,
  output logic               sine_clamped_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [12:0]        cfg_data_i
);

  logic        en;
  logic [12:0] lock_margin_q;
  logic        vld_q [qte_pkg::PIPE_DEPTH];

  logic signed [31:0] xx_q, yy_q, zz_q, ww_q, wy_q, xz_q, xy_q, wz_q, wx_q, yz_q;

  qte_pkg::cval_t e_xx, e_yy, e_zz, e_ww, e_wy, e_xz, e_xy, e_wz, e_wx, e_yz;
  qte_pkg::cval_t s_raw;
  qte_pkg::cval_t s_cl;
  logic           clamp_d;

  logic signed [31:0] s2_q;
  logic               clamp2_q;
  qte_pkg::cval_t     ny_q, nx_q, ry_q, rx_q, ly_q, lx_q;

  logic [30:0]            s_mag;
  logic [61:0]            sq;
  logic [qte_pkg::VW-1:0] ssq_q;
  logic signed [31:0]     s3_q;

  qte_pkg::sqrt_t sq_row [qte_pkg::SQRT_CELLS+1];
  qte_pkg::cval_t pitch_y;
  qte_pkg::cval_t pitch_x;

  logic [15:0] pitch_ang, yaw_ang, roll_ang, lyaw_ang;

  qte_pkg::angles_t ang_q   [qte_pkg::ANG_DLY];
  logic             clamp_q [qte_pkg::CLAMP_DLY];

  logic signed [15:0] pa;
  logic signed [15:0] pitch_p_q;
  qte_pkg::angles_t   ang_p_q;
  logic               clamp_p_q;

  logic [15:0] mag;
  logic [15:0] gap;
  logic        lock;
  logic [15:0] yaw_sel;

  assign en          = !vld_q[qte_pkg::PIPE_DEPTH-1] || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = vld_q[qte_pkg::PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_margin_q <= '0;
    end else if (cfg_valid_i) begin
      lock_margin_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < qte_pkg::PIPE_DEPTH; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < qte_pkg::PIPE_DEPTH; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
      ww_q <= quat_w_i * quat_w_i;
      wy_q <= quat_w_i * quat_y_i;
      xz_q <= quat_x_i * quat_z_i;
      xy_q <= quat_x_i * quat_y_i;
      wz_q <= quat_w_i * quat_z_i;
      wx_q <= quat_w_i * quat_x_i;
      yz_q <= quat_y_i * quat_z_i;
    end
  end

  always_comb begin
    e_xx  = qte_pkg::CW'(xx_q);
    e_yy  = qte_pkg::CW'(yy_q);
    e_zz  = qte_pkg::CW'(zz_q);
    e_ww  = qte_pkg::CW'(ww_q);
    e_wy  = qte_pkg::CW'(wy_q);
    e_xz  = qte_pkg::CW'(xz_q);
    e_xy  = qte_pkg::CW'(xy_q);
    e_wz  = qte_pkg::CW'(wz_q);
    e_wx  = qte_pkg::CW'(wx_q);
    e_yz  = qte_pkg::CW'(yz_q);
    s_raw = (e_wy - e_xz) <<< 1;
    s_cl  = s_raw;
    clamp_d = 1'b0;
    if (s_raw > qte_pkg::ONE_Q30) begin
      s_cl    = qte_pkg::ONE_Q30;
      clamp_d = 1'b1;
    end
    if (s_raw < -qte_pkg::ONE_Q30) begin
      s_cl    = -qte_pkg::ONE_Q30;
      clamp_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q     <= s_cl[31:0];
      clamp2_q <= clamp_d;
      ny_q     <= (e_xy + e_wz) <<< 1;
      nx_q     <= e_xx - e_yy - e_zz + e_ww;
      ry_q     <= (e_wx + e_yz) <<< 1;
      rx_q     <= e_ww - e_xx - e_yy + e_zz;
      ly_q     <= (e_yz <<< 1) - (e_wx <<< 1);
      lx_q     <= (e_xz <<< 1) + (e_wy <<< 1);
    end
  end

  always_comb begin
    s_mag = s2_q[31] ? 31'(-s2_q) : s2_q[30:0];
    sq    = 62'(s_mag) * 62'(s_mag);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ssq_q <= sq[qte_pkg::VW-1:0];
      s3_q  <= s2_q;
    end
  end

  assign sq_row[0].v   = qte_pkg::ONE_Q60 - ssq_q;
  assign sq_row[0].res = '0;
  assign sq_row[0].s   = s3_q;

  for (genvar j = 0; j < qte_pkg::SQRT_CELLS; j++) begin : g_sqrt
    qte_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .k_i   (5'(qte_pkg::SQRT_CELLS - 1 - j)),
      .d_i   (sq_row[j]),
      .q_o   (sq_row[j+1])
    );
  end

  assign pitch_y = qte_pkg::CW'(sq_row[qte_pkg::SQRT_CELLS].s);
  assign pitch_x = $signed({5'b0, sq_row[qte_pkg::SQRT_CELLS].res[30:0]});

  qte_cordic u_pitch (.clk_i(clk_i), .en_i(en), .y_i(pitch_y), .x_i(pitch_x),
                      .angle_o(pitch_ang));
  qte_cordic u_yaw   (.clk_i(clk_i), .en_i(en), .y_i(ny_q), .x_i(nx_q),
                      .angle_o(yaw_ang));
  qte_cordic u_roll  (.clk_i(clk_i), .en_i(en), .y_i(ry_q), .x_i(rx_q),
                      .angle_o(roll_ang));
  qte_cordic u_lyaw  (.clk_i(clk_i), .en_i(en), .y_i(ly_q), .x_i(lx_q),
                      .angle_o(lyaw_ang));

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q[0].yaw  <= yaw_ang;
      ang_q[0].roll <= roll_ang;
      ang_q[0].lyaw <= lyaw_ang;
      for (int i = 1; i < qte_pkg::ANG_DLY; i++) begin
        ang_q[i] <= ang_q[i-1];
      end
      clamp_q[0] <= clamp2_q;
      for (int i = 1; i < qte_pkg::CLAMP_DLY; i++) begin
        clamp_q[i] <= clamp_q[i-1];
      end
    end
  end

  always_comb begin
    pa = $signed(pitch_ang);
    if (pa > qte_pkg::PITCH_MAX) begin
      pa = qte_pkg::PITCH_MAX;
    end
    if (pa < -qte_pkg::PITCH_MAX) begin
      pa = -qte_pkg::PITCH_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pitch_p_q <= pa;
      ang_p_q   <= ang_q[qte_pkg::ANG_DLY-1];
      clamp_p_q <= clamp_q[qte_pkg::CLAMP_DLY-1];
    end
  end

  always_comb begin
    mag  = pitch_p_q[15] ? 16'(-pitch_p_q) : 16'(pitch_p_q);
    gap  = 16'(qte_pkg::PITCH_MAX) - mag;
    lock = gap <= {3'b000, lock_margin_q};
    if (!lock) begin
      yaw_sel = ang_p_q.yaw;
    end else if (pitch_p_q[15]) begin
      yaw_sel = qte_pkg::HALF_TURN - ang_p_q.lyaw;
    end else begin
      yaw_sel = ang_p_q.lyaw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_angle_o   <= lock ? 16'sd0 : $signed(ang_p_q.roll);
      pitch_angle_o  <= pitch_p_q;
      yaw_angle_o    <= $signed(yaw_sel);
      gimbal_lock_o  <= lock;
      sine_clamped_o <= clamp_p_q;
    end
  end

  a_lock_roll_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && gimbal_lock_o |-> roll_angle_o == 16'sd0)
    else $error("roll not zero on lock path");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pitch_angle_o <= qte_pkg::PITCH_MAX) &&
                    (pitch_angle_o >= -qte_pkg::PITCH_MAX))
    else $error("pitch outside quarter turn");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while pipeline stalled");

  a_stall_keeps_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(yaw_angle_o))
    else $error("held result lost");

endmodule
